[sv/brr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brr_pkg
// Shared types and constants for the block decoder: the data byte item
// that passes from the front to the back through the queue.
// ----------------------------------------------------------------------------
package brr_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned SHIFT_W     = 4;
	localparam int unsigned FILTER_W    = 2;
	localparam int unsigned POS_W       = 4;
	localparam int unsigned SAMPLE_W    = 16;
	localparam int unsigned HIST_W      = 16;
	localparam int unsigned DATA_BYTES  = 8;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// predictor and sum width, headroom over the 16-bit clamp range
	localparam int unsigned ACC_W       = 20;

	// shift codes above this give the fixed +-2048 value
	localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'hc;

	typedef enum logic [FILTER_W-1:0] {
		FILT_NONE = 2'd0,
		FILT_ONE  = 2'd1,
		FILT_TWO  = 2'd2,
		FILT_THREE = 2'd3
	} filter_t;

	// one data byte with the header state it is decoded under
	typedef struct packed {
		logic [BYTE_W-1:0]  data;
		logic [SHIFT_W-1:0] shift;
		filter_t            filter;
		logic               loop_bit;
		logic               last_end;   // final byte of a block with end bit set
		logic               clr_hist;   // clear history before the high nibble
	} item_t;

	// queue handshake status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

[sv/brr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brr_front
// Accepts stream bytes, parses headers into block state and pushes each
// data byte with its block state into the queue.
// ----------------------------------------------------------------------------
module brr_front (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire [brr_pkg::BYTE_W-1:0]  data_byte,
	input  wire                        first_of_sample,
	input  brr_pkg::q_status_t         q_status,
	output logic                       push,
	output brr_pkg::item_t             push_item
);
	import brr_pkg::*;

	logic [POS_W-1:0]   pos_q;
	logic [SHIFT_W-1:0] shift_q;
	filter_t            filter_q;
	logic               loop_q;
	logic               end_q;
	logic               clr_pend_q;
	logic               beat;
	logic               is_header;

	// a beat waits only for queue room
	assign in_ready  = !q_status.full;
	assign beat      = in_valid && in_ready;
	assign is_header = first_of_sample || (pos_q == '0);
	assign push      = beat && !is_header;

	// item for the back end
	always_comb begin
		push_item.data     = data_byte;
		push_item.shift    = shift_q;
		push_item.filter   = filter_q;
		push_item.loop_bit = loop_q;
		push_item.last_end = end_q && (pos_q == POS_W'(DATA_BYTES));
		push_item.clr_hist = clr_pend_q;
	end

	// block state and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			shift_q    <= '0;
			filter_q   <= FILT_NONE;
			loop_q     <= 1'b0;
			end_q      <= 1'b0;
			clr_pend_q <= 1'b0;
		end else if (beat) begin
			if (is_header) begin
				shift_q    <= data_byte[7:4];
				filter_q   <= filter_t'(data_byte[3:2]);
				loop_q     <= data_byte[1];
				end_q      <= data_byte[0];
				pos_q      <= POS_W'(1);
				clr_pend_q <= clr_pend_q || first_of_sample;
			end else begin
				clr_pend_q <= 1'b0;
				pos_q      <= (pos_q == POS_W'(DATA_BYTES)) ? '0 : pos_q + POS_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[sv/brr_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brr_queue
// Short register queue of data byte items between the front and the back.
// ----------------------------------------------------------------------------
module brr_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  brr_pkg::item_t     push_item,
	input  wire                pop,
	output brr_pkg::item_t     head_item,
	output brr_pkg::q_status_t q_status
);
	import brr_pkg::*;

	item_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign head_item      = slot_q[rd_ptr_q];
	assign q_status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/brr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brr_back
// Decodes one nibble per cycle from the queue head (held while the queue is
// empty or a sample waits): scale, predict, clamp and wrap into an output register.
// ----------------------------------------------------------------------------
module brr_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  brr_pkg::item_t               head_item,
	input  brr_pkg::q_status_t           q_status,
	output logic                         pop,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [brr_pkg::SAMPLE_W-1:0] sample_out,
	output logic                         last_of_run,
	output logic                         end_of_sample,
	output logic                         loop_flag
);
	import brr_pkg::*;

	logic                       phase_q;    // 0 high nibble, 1 low nibble
	logic signed [HIST_W-1:0]   hist1_q;
	logic signed [HIST_W-1:0]   hist2_q;
	logic                       out_valid_q;
	logic [SAMPLE_W-1:0]        sample_q;
	logic                       last_q;
	logic                       end_q;
	logic                       loop_q;

	logic                       step;
	logic [3:0]                 nib;
	logic signed [16:0]         nib_ext;
	logic signed [16:0]         nib_shl;
	logic signed [ACC_W-1:0]    scaled;
	logic signed [ACC_W-1:0]    p1;
	logic signed [ACC_W-1:0]    p2;
	logic signed [ACC_W-1:0]    pred;
	logic signed [ACC_W-1:0]    sum;
	logic signed [ACC_W-1:0]    clamped;
	logic [14:0]                wrapped;

	assign step = !q_status.empty && (!out_valid_q || out_ready);
	assign pop  = step && phase_q;

	// scaled nibble
	always_comb begin
		nib     = phase_q ? head_item.data[3:0] : head_item.data[7:4];
		nib_ext = {{13{nib[3]}}, nib};
		nib_shl = nib_ext <<< head_item.shift;
		if (head_item.shift > SHIFT_MAX) begin
			scaled = nib[3] ? -ACC_W'(signed'(2048)) : ACC_W'(signed'(2048));
		end else begin
			scaled = ACC_W'(nib_shl >>> 1);
		end
	end

	// predictor over the last two samples
	always_comb begin
		if (head_item.clr_hist && !phase_q) begin
			p1 = '0;
			p2 = '0;
		end else begin
			p1 = ACC_W'(hist1_q);
			p2 = ACC_W'(hist2_q);
		end
		unique case (head_item.filter)
			FILT_NONE: pred = '0;
			FILT_ONE:  pred = p1 - (p1 >>> 4);
			FILT_TWO:  pred = (p1 <<< 1) + ((-(p1 + (p1 <<< 1))) >>> 5) - p2 + (p2 >>> 4);
			FILT_THREE: pred = (p1 <<< 1) + ((-((p1 <<< 3) + (p1 <<< 2) + p1)) >>> 6)
					- p2 + (((p2 <<< 1) + p2) >>> 4);
			default:   pred = '0;
		endcase
	end

	// clamp to 16 bits, then keep the low 15 bits as a signed value
	always_comb begin
		sum = scaled + pred;
		if (sum > ACC_W'(signed'(32'sh7fff))) begin
			clamped = ACC_W'(signed'(32'sh7fff));
		end else if (sum < ACC_W'(signed'(-32'sh8000))) begin
			clamped = ACC_W'(signed'(-32'sh8000));
		end else begin
			clamped = sum;
		end
		wrapped = clamped[14:0];
	end

	// history and nibble phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			hist1_q <= '0;
			hist2_q <= '0;
		end else if (step) begin
			phase_q <= !phase_q;
			hist2_q <= (head_item.clr_hist && !phase_q) ? '0 : hist1_q;
			hist1_q <= {wrapped[14], wrapped};
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (step) begin
			sample_q <= {wrapped, 1'b0};
			last_q   <= phase_q;
			end_q    <= phase_q && head_item.last_end;
			loop_q   <= head_item.loop_bit;
		end
	end

	assign out_valid     = out_valid_q;
	assign sample_out    = sample_q;
	assign last_of_run   = last_q;
	assign end_of_sample = end_q;
	assign loop_flag     = loop_q;

endmodule

`default_nettype wire

[sv/brr_adpcm_block_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brr_adpcm_block_decoder
// Decodes 9-byte ADPCM blocks (header plus eight data bytes) into 16-bit
// samples, two per data byte, high nibble first.
// ----------------------------------------------------------------------------
// channel  handshake             payload
// in       in_valid / in_ready   data_byte, first_of_sample
// out      out_valid / out_ready sample_out, last_of_run, end_of_sample,
//                                loop_flag
//
// a header beat gives no sample; a data byte gives two samples. the single
// nibble decoder and its history loop decode one nibble at a time, and a
// data byte leaves the queue once its low nibble is decoded. a sample passes
// the queue and then the output register. reset clears block state, history
// and the queue. a two-entry queue parts front and back, and the output
// register takes a new sample in the same cycle its waiting one is taken.
// ----------------------------------------------------------------------------
module brr_adpcm_block_decoder (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [brr_pkg::BYTE_W-1:0]    data_byte,
	input  wire                          first_of_sample,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [brr_pkg::SAMPLE_W-1:0] sample_out,
	output logic                         last_of_run,
	output logic                         end_of_sample,
	output logic                         loop_flag
);
	import brr_pkg::*;

	logic      push;
	logic      pop;
	item_t     push_item;
	item_t     head_item;
	q_status_t q_status;

	// header parse and byte classification
	brr_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.first_of_sample (first_of_sample),
		.q_status        (q_status),
		.push            (push),
		.push_item       (push_item)
	);

	// data byte queue
	brr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_status  (q_status)
	);

	// nibble decode and output register
	brr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_item     (head_item),
		.q_status      (q_status),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sample_out    (sample_out),
		.last_of_run   (last_of_run),
		.end_of_sample (end_of_sample),
		.loop_flag     (loop_flag)
	);

endmodule

`default_nettype wire

[verif/brr_decode_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_decode_checker
// Watches both channels of the block decoder, keeps its own copy of block
// state and predictor history, predicts the samples of every data beat and
// compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module brr_decode_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire                          in_ready,
	input  wire [brr_pkg::BYTE_W-1:0]    data_byte,
	input  wire                          first_of_sample,
	input  wire                          out_valid,
	input  wire                          out_ready,
	input  wire [brr_pkg::SAMPLE_W-1:0]  sample_out,
	input  wire                          last_of_run,
	input  wire                          end_of_sample,
	input  wire                          loop_flag,
	output int                           mismatch_count,
	output int                           pending_count
);
	import brr_pkg::*;

	localparam int CLAMP_HI = 32'sh7fff;
	localparam int CLAMP_LO = -32'sh8000;
	localparam int WRAP_HI  = 32'sh3fff;
	localparam int WRAP_LO  = -32'sh4000;
	localparam int FIXED_MAG = 1 << 11;

	typedef struct packed {
		logic [SAMPLE_W-1:0] pcm;
		logic                last_run;
		logic                end_smp;
		logic                loop_bit;
	} sample_beat_t;

	sample_beat_t pending_samples[$];

	// block state and predictor history
	logic [POS_W-1:0]   blk_pos;
	logic [SHIFT_W-1:0] blk_shift;
	filter_t            blk_filter;
	logic               blk_end;
	logic               blk_loop;
	logic [HIST_W-1:0]  hist_new;
	logic [HIST_W-1:0]  hist_old;

	// one nibble through scale, predictor, clamp and wrap; updates history
	function automatic logic [SAMPLE_W-1:0] decode_nibble_pcm(input logic [3:0] nib);
		int n;
		int p1;
		int p2;
		int acc;
		int pred;
		n  = $signed(nib);
		p1 = $signed(hist_new);
		p2 = $signed(hist_old);
		if (blk_shift <= SHIFT_MAX) begin
			acc = (n <<< blk_shift) >>> 1;
		end else begin
			acc = (n >= 0) ? FIXED_MAG : -FIXED_MAG;
		end
		case (blk_filter)
			FILT_ONE: begin
				pred = p1 - (p1 >>> 4);
			end
			FILT_TWO: begin
				pred = 2 * p1 + ((-3 * p1) >>> 5) - p2 + (p2 >>> 4);
			end
			FILT_THREE: begin
				pred = 2 * p1 + ((-13 * p1) >>> 6) - p2 + ((3 * p2) >>> 4);
			end
			default: begin
				pred = 0;
			end
		endcase
		acc += pred;
		if (acc > CLAMP_HI) begin
			acc = CLAMP_HI;
		end else if (acc < CLAMP_LO) begin
			acc = CLAMP_LO;
		end
		if (acc > WRAP_HI) begin
			acc -= 32768;
		end else if (acc < WRAP_LO) begin
			acc += 32768;
		end
		hist_old = hist_new;
		hist_new = acc[HIST_W-1:0];
		return {acc[SAMPLE_W-2:0], 1'b0};
	endfunction

	function automatic void check_field(input string fname, input logic [SAMPLE_W-1:0] expv,
		input logic [SAMPLE_W-1:0] gotv);
		if (gotv !== expv) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, expv, gotv);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_beat_t exp_beat;
		sample_beat_t hi_beat;
		sample_beat_t lo_beat;
		if (!arst_n) begin
			blk_pos    = '0;
			blk_shift  = '0;
			blk_filter = FILT_NONE;
			blk_end    = 1'b0;
			blk_loop   = 1'b0;
			hist_new   = '0;
			hist_old   = '0;
			pending_samples.delete();
			mismatch_count = 0;
		end else begin
			// result beat against the oldest prediction
			if (out_valid && out_ready) begin
				if (pending_samples.size() == 0) begin
					$display("%0t: unexpected sample beat, expected none, actual 0x%0h %b%b%b",
						$time, sample_out, last_of_run, end_of_sample, loop_flag);
					mismatch_count++;
				end else begin
					exp_beat = pending_samples.pop_front();
					check_field("sample_out", exp_beat.pcm, sample_out);
					check_field("last_of_run", exp_beat.last_run, last_of_run);
					check_field("end_of_sample", exp_beat.end_smp, end_of_sample);
					check_field("loop_flag", exp_beat.loop_bit, loop_flag);
				end
			end
			// input beat: header updates block state, data byte gives two samples
			if (in_valid && in_ready) begin
				if (first_of_sample) begin
					hist_new = '0;
					hist_old = '0;
					blk_pos  = '0;
				end
				if (blk_pos == 0 || blk_pos > DATA_BYTES) begin
					blk_shift  = data_byte[7:4];
					blk_filter = filter_t'(data_byte[3:2]);
					blk_loop   = data_byte[1];
					blk_end    = data_byte[0];
					blk_pos    = POS_W'(1);
				end else begin
					hi_beat.pcm      = decode_nibble_pcm(data_byte[7:4]);
					hi_beat.last_run = 1'b0;
					hi_beat.end_smp  = 1'b0;
					hi_beat.loop_bit = blk_loop;
					lo_beat.pcm      = decode_nibble_pcm(data_byte[3:0]);
					lo_beat.last_run = 1'b1;
					lo_beat.end_smp  = (blk_pos == DATA_BYTES) && blk_end;
					lo_beat.loop_bit = blk_loop;
					pending_samples.push_back(hi_beat);
					pending_samples.push_back(lo_beat);
					blk_pos = (blk_pos == DATA_BYTES) ? '0 : blk_pos + POS_W'(1);
				end
			end
		end
		pending_count = pending_samples.size();
	end

endmodule

[verif/tb_brr_adpcm_block_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brr_adpcm_block_decoder
// Drives block streams into the decoder: a directed run over shift, filter,
// loop, end and mid-block restarts, then random samples made of well-formed
// blocks with some stray starts and noise, under several idle and stall
// mixes. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_brr_adpcm_block_decoder;
	import brr_pkg::*;

	logic                clk             = 1'b0;
	logic                arst_n          = 1'b0;
	logic                in_valid        = 1'b0;
	logic [BYTE_W-1:0]   data_byte       = '0;
	logic                first_of_sample = 1'b0;
	logic                out_ready       = 1'b0;
	logic                in_ready;
	logic                out_valid;
	logic [SAMPLE_W-1:0] sample_out;
	logic                last_of_run;
	logic                end_of_sample;
	logic                loop_flag;

	int mismatch_count;
	int pending_count;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int beats_sent     = 0;

	brr_adpcm_block_decoder u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.first_of_sample (first_of_sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.sample_out      (sample_out),
		.last_of_run     (last_of_run),
		.end_of_sample   (end_of_sample),
		.loop_flag       (loop_flag)
	);

	brr_decode_checker u_decode_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.first_of_sample (first_of_sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.sample_out      (sample_out),
		.last_of_run     (last_of_run),
		.end_of_sample   (end_of_sample),
		.loop_flag       (loop_flag),
		.mismatch_count  (mismatch_count),
		.pending_count   (pending_count)
	);

	always #2 clk = ~clk;

	// receiver stalls at random
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic [BYTE_W-1:0] make_header(input logic [SHIFT_W-1:0] shift,
		input filter_t filt, input logic loop_bit, input logic end_bit);
		return {shift, filt, loop_bit, end_bit};
	endfunction

	// mostly in-range shifts, some of the fixed-value ones
	function automatic logic [BYTE_W-1:0] rand_header();
		logic [SHIFT_W-1:0] shift;
		if ($urandom_range(99) < 20) begin
			shift = SHIFT_W'($urandom_range(15, 13));
		end else begin
			shift = SHIFT_W'($urandom_range(12, 0));
		end
		return make_header(shift, filter_t'($urandom_range(3)), 1'($urandom_range(1)),
			1'($urandom_range(1)));
	endfunction

	function automatic logic [BYTE_W-1:0] rand_data();
		logic [BYTE_W-1:0] corner[8];
		corner = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h08, 8'hf7, 8'h77, 8'h88};
		if ($urandom_range(99) < 15) begin
			return corner[$urandom_range(7)];
		end
		return BYTE_W'($urandom_range(255));
	endfunction

	// one input beat, with random idle cycles ahead of it
	task automatic send_beat(input logic [BYTE_W-1:0] b, input logic first);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid        = 1'b1;
		data_byte       = b;
		first_of_sample = first;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		beats_sent++;
	endtask

	// hold the sender off until every predicted sample has come out
	task automatic drain();
		@(negedge clk);
		in_valid        = 1'b0;
		first_of_sample = 1'b0;
		wait (pending_count == 0);
	endtask

	// random samples: well-formed blocks, stray restarts and some noise
	task automatic run_random(input int n_beats);
		int goal;
		int n_blocks;
		goal = beats_sent + n_beats;
		while (beats_sent < goal) begin
			if ($urandom_range(99) < 5) begin
				repeat ($urandom_range(12, 1)) begin
					send_beat(BYTE_W'($urandom_range(255)), ($urandom_range(99) < 20));
				end
			end else begin
				n_blocks = $urandom_range(4, 1);
				send_beat(rand_header(), 1'b1);
				for (int blk = 0; blk < n_blocks; blk++) begin
					if (blk > 0) begin
						send_beat(rand_header(), 1'b0);
					end
					for (int i = 0; i < DATA_BYTES; i++) begin
						if ($urandom_range(99) < 2) begin
							send_beat(rand_header(), 1'b1);
						end else begin
							send_beat(rand_data(), 1'b0);
						end
					end
				end
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// shift 12, no filter: nibble extremes
		send_beat(make_header(4'd12, FILT_NONE, 1'b0, 1'b0), 1'b1);
		send_beat(8'h7f, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(8'hff, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'h88, 1'b0);
		send_beat(8'h77, 1'b0);
		send_beat(8'h01, 1'b0);
		send_beat(8'hf0, 1'b0);
		// fixed +-2048 with filter one; end and loop set
		send_beat(make_header(4'd15, FILT_ONE, 1'b1, 1'b1), 1'b0);
		send_beat(8'h70, 1'b0);
		send_beat(8'h87, 1'b0);
		repeat (6) send_beat(8'h7f, 1'b0);
		// filter three, then a new sample starts mid-block with filter two
		send_beat(make_header(4'd12, FILT_THREE, 1'b1, 1'b0), 1'b0);
		repeat (3) send_beat(8'h77, 1'b0);
		send_beat(make_header(4'd13, FILT_TWO, 1'b1, 1'b1), 1'b1);
		send_beat(8'h80, 1'b0);
		send_beat(8'h80, 1'b0);
		drain();

		// no idling, sender idle, receiver stall, both, then no idling again
		run_random(220);
		drain();
		send_idle_pct = 67;
		run_random(220);
		drain();
		send_idle_pct  = 0;
		recv_stall_pct = 67;
		run_random(220);
		drain();
		send_idle_pct  = 16;
		recv_stall_pct = 16;
		run_random(220);
		drain();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random(220);
		drain();

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
